// ===== design/etq_pkg.sv =====
// Shared types, constants and helper functions for the Euler angle to
// quaternion converter. No dependencies; every other design file imports it.

package etq_pkg;

    localparam int AngleW   = 16;
    localparam int QuatW    = 16;
    localparam int CordicN  = 20;
    localparam int XyW      = 27;
    localparam int ZW       = 24;
    localparam int CsW      = 18;
    localparam int PairW    = 2 * CsW;
    localparam int TripleW  = PairW + CsW;
    localparam int SumW     = TripleW + 2;
    localparam int RoundSh  = 34;
    localparam int SatW     = SumW - RoundSh;

    localparam logic signed [XyW-1:0]   CordicGain = XyW'(10188014);
    localparam logic signed [ZW-1:0]    PiQ20      = ZW'(3294199);
    localparam logic signed [ZW-1:0]    HalfPiQ20  = ZW'(1647099);
    localparam logic signed [QuatW-1:0] OneQ14     = QuatW'(16384);

    typedef struct packed {
        logic signed [XyW-1:0] x;
        logic signed [XyW-1:0] y;
        logic signed [ZW-1:0]  z;
        logic                  flip;
    } t_lane;

    typedef struct packed {
        t_lane roll;
        t_lane pitch;
        t_lane yaw;
    } t_stage;

    typedef struct packed {
        logic signed [QuatW-1:0] w;
        logic signed [QuatW-1:0] x;
        logic signed [QuatW-1:0] y;
        logic signed [QuatW-1:0] z;
    } t_quat;

    function automatic logic signed [ZW-1:0] etq_atan(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            5'd0:    v = ZW'(823550);
            5'd1:    v = ZW'(486170);
            5'd2:    v = ZW'(256879);
            5'd3:    v = ZW'(130396);
            5'd4:    v = ZW'(65451);
            5'd5:    v = ZW'(32757);
            5'd6:    v = ZW'(16383);
            5'd7:    v = ZW'(8192);
            5'd8:    v = ZW'(4096);
            5'd9:    v = ZW'(2048);
            5'd10:   v = ZW'(1024);
            5'd11:   v = ZW'(512);
            5'd12:   v = ZW'(256);
            5'd13:   v = ZW'(128);
            5'd14:   v = ZW'(64);
            5'd15:   v = ZW'(32);
            5'd16:   v = ZW'(16);
            5'd17:   v = ZW'(8);
            5'd18:   v = ZW'(4);
            5'd19:   v = ZW'(2);
            default: v = '0;
        endcase
        return v;
    endfunction

    // Applies the quadrant flip, then rounds Q.24 to Q.16 half upward.
    function automatic logic signed [CsW-1:0] etq_round_cs(
        input logic signed [XyW-1:0] v,
        input logic                  flip
    );
        logic signed [XyW:0] s;
        logic signed [XyW:0] t;
        s = flip ? -$signed({v[XyW-1], v}) : $signed({v[XyW-1], v});
        t = s + (XyW+1)'(128);
        return t[CsW+7:8];
    endfunction

    // Rounds a Q.48 sum to Q.14 half upward and clamps it to plus or minus one.
    function automatic logic signed [QuatW-1:0] etq_to_q14(
        input logic signed [SumW-1:0] sum
    );
        logic signed [SumW-1:0] t;
        logic signed [SatW-1:0] q;
        logic signed [QuatW-1:0] r;
        t = sum + (SumW'(1) <<< (RoundSh - 1));
        q = t[SumW-1:RoundSh];
        if (q > $signed(SatW'(OneQ14))) begin
            r = OneQ14;
        end else if (q < -$signed(SatW'(OneQ14))) begin
            r = -OneQ14;
        end else begin
            r = q[QuatW-1:0];
        end
        return r;
    endfunction

endpackage

// ===== design/etq_angle_if.sv =====
// Request channel carrying roll, pitch and yaw angles in Q2.13.
// Depends on etq_pkg for field widths.

interface etq_angle_if;
    import etq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [AngleW-1:0] roll_angle;
    logic signed [AngleW-1:0] pitch_angle;
    logic signed [AngleW-1:0] yaw_angle;

    modport source (output valid, output roll_angle, output pitch_angle,
                    output yaw_angle, input ready);
    modport sink   (input valid, input roll_angle, input pitch_angle,
                    input yaw_angle, output ready);
endinterface

// ===== design/etq_quat_if.sv =====
// Result channel carrying the quaternion components in Q1.14.
// Depends on etq_pkg for field widths.

interface etq_quat_if;
    import etq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [QuatW-1:0] quat_w;
    logic signed [QuatW-1:0] quat_x;
    logic signed [QuatW-1:0] quat_y;
    logic signed [QuatW-1:0] quat_z;

    modport source (output valid, output quat_w, output quat_x, output quat_y,
                    output quat_z, input ready);
    modport sink   (input valid, input quat_w, input quat_x, input quat_y,
                    input quat_z, output ready);
endinterface

// ===== design/etq_cordic_cell.sv =====
// One CORDIC rotation step applied to the roll, pitch and yaw lanes.
// Depends on etq_pkg for the lane types and the arctangent table.

module etq_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  etq_pkg::t_stage i_data,
    output logic            o_ready,
    output logic            o_valid,
    output etq_pkg::t_stage o_data,
    input  logic            i_ready
);
    import etq_pkg::*;

    localparam logic signed [ZW-1:0] Atan = etq_atan(5'(STEP));

    function automatic t_lane rotate(input t_lane a);
        t_lane r;
        logic signed [XyW-1:0] dx;
        logic signed [XyW-1:0] dy;
        dx = a.y >>> STEP;
        dy = a.x >>> STEP;
        r.flip = a.flip;
        if (a.z >= 0) begin
            r.x = a.x - dx;
            r.y = a.y + dy;
            r.z = a.z - Atan;
        end else begin
            r.x = a.x + dx;
            r.y = a.y - dy;
            r.z = a.z + Atan;
        end
        return r;
    endfunction

    logic   r_valid;
    t_stage r_data;
    t_stage n_data;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_data.roll  = rotate(i_data.roll);
        n_data.pitch = rotate(i_data.pitch);
        n_data.yaw   = rotate(i_data.yaw);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// ===== design/etq_combine.sv =====
// Rounds the half-angle cosines and sines, forms the triple products and
// sums them into saturated quaternion components. Depends on etq_pkg.

module etq_combine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  etq_pkg::t_stage i_data,
    output logic            o_ready,
    output logic            o_valid,
    output etq_pkg::t_quat  o_data,
    input  logic            i_ready
);
    import etq_pkg::*;

    logic signed [CsW-1:0] cr, sr, cp, sp, cy, sy;

    logic                      r_va, r_vb, r_vc;
    logic                      en_a, en_b, en_c;
    logic signed [PairW-1:0]   r_crcp, r_srsp, r_srcp, r_crsp;
    logic signed [CsW-1:0]     r_cy, r_sy;
    logic signed [TripleW-1:0] r_w1, r_w2, r_x1, r_x2, r_y1, r_y2, r_z1, r_z2;
    t_quat                     r_quat;
    t_quat                     n_quat;

    assign en_c    = !r_vc || i_ready;
    assign en_b    = !r_vb || en_c;
    assign en_a    = !r_va || en_b;
    assign o_ready = en_a;

    always_comb begin
        cr = etq_round_cs(i_data.roll.x,  i_data.roll.flip);
        sr = etq_round_cs(i_data.roll.y,  i_data.roll.flip);
        cp = etq_round_cs(i_data.pitch.x, i_data.pitch.flip);
        sp = etq_round_cs(i_data.pitch.y, i_data.pitch.flip);
        cy = etq_round_cs(i_data.yaw.x,   i_data.yaw.flip);
        sy = etq_round_cs(i_data.yaw.y,   i_data.yaw.flip);
    end

    always_comb begin
        n_quat.w = etq_to_q14(SumW'(r_w1) + SumW'(r_w2));
        n_quat.x = etq_to_q14(SumW'(r_x1) - SumW'(r_x2));
        n_quat.y = etq_to_q14(SumW'(r_y1) + SumW'(r_y2));
        n_quat.z = etq_to_q14(SumW'(r_z1) - SumW'(r_z2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (en_a) begin
                r_va <= i_valid;
            end
            if (en_b) begin
                r_vb <= r_va;
            end
            if (en_c) begin
                r_vc <= r_vb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a && i_valid) begin
            r_crcp <= cr * cp;
            r_srsp <= sr * sp;
            r_srcp <= sr * cp;
            r_crsp <= cr * sp;
            r_cy   <= cy;
            r_sy   <= sy;
        end
        if (en_b && r_va) begin
            r_w1 <= r_crcp * r_cy;
            r_w2 <= r_srsp * r_sy;
            r_x1 <= r_srcp * r_cy;
            r_x2 <= r_crsp * r_sy;
            r_y1 <= r_crsp * r_cy;
            r_y2 <= r_srcp * r_sy;
            r_z1 <= r_crcp * r_sy;
            r_z2 <= r_srsp * r_cy;
        end
        if (en_c && r_vb) begin
            r_quat <= n_quat;
        end
    end

    assign o_valid = r_vc;
    assign o_data  = r_quat;
endmodule

// ===== design/euler_to_quaternion.sv =====
// Euler angle (ZYX) to unit quaternion converter, top level.
// Depends on etq_pkg, etq_angle_if, etq_quat_if, etq_cordic_cell and etq_combine.
//
// The request channel i_angle carries roll, pitch and yaw in Q2.13 radians;
// the result channel o_quat returns w, x, y and z in Q1.14, each saturated
// to plus or minus one. Both channels use a valid/ready handshake and every
// request gives exactly one result, in order.
// Each half angle is folded into plus or minus pi/2 on entry and then runs
// through a row of twenty CORDIC cells, one rotation step per cell, with all
// three angles carried side by side. Three more stages round the cosines and
// sines, form the triple products and sum, round and clamp them.
// An accepted request passes through the twenty cells and then the three
// product stages. Throughput is one request per cycle while the receiver is
// ready. Every stage has its own valid bit, so a stalled receiver only holds
// the stages that are full; empty stages behind it keep taking requests, and
// the whole pipeline stops only once every stage holds a result.
// Reset clears all valid bits; no result is in flight afterward.

module euler_to_quaternion (
    input  logic       i_clk,
    input  logic       i_rst_n,
    etq_angle_if.sink  i_angle,
    etq_quat_if.source o_quat
);
    import etq_pkg::*;

    logic   w_valid [0:CordicN];
    logic   w_ready [0:CordicN];
    t_stage w_stage [0:CordicN];
    t_quat  w_quat;

    function automatic t_lane prep(input logic signed [AngleW-1:0] a);
        t_lane r;
        logic signed [ZW-1:0] z;
        z = {{(ZW-AngleW-6){a[AngleW-1]}}, a, 6'b0};
        r.x = CordicGain;
        r.y = '0;
        if (z > HalfPiQ20) begin
            r.z    = z - PiQ20;
            r.flip = 1'b1;
        end else if (z < -HalfPiQ20) begin
            r.z    = z + PiQ20;
            r.flip = 1'b1;
        end else begin
            r.z    = z;
            r.flip = 1'b0;
        end
        return r;
    endfunction

    assign w_valid[0]       = i_angle.valid;
    assign i_angle.ready    = w_ready[0];
    assign w_stage[0].roll  = prep(i_angle.roll_angle);
    assign w_stage[0].pitch = prep(i_angle.pitch_angle);
    assign w_stage[0].yaw   = prep(i_angle.yaw_angle);

    for (genvar k = 0; k < CordicN; k++) begin : g_cell
        etq_cordic_cell #(
            .STEP (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .i_data  (w_stage[k]),
            .o_ready (w_ready[k]),
            .o_valid (w_valid[k+1]),
            .o_data  (w_stage[k+1]),
            .i_ready (w_ready[k+1])
        );
    end

    etq_combine u_combine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[CordicN]),
        .i_data  (w_stage[CordicN]),
        .o_ready (w_ready[CordicN]),
        .o_valid (o_quat.valid),
        .o_data  (w_quat),
        .i_ready (o_quat.ready)
    );

    assign o_quat.quat_w = w_quat.w;
    assign o_quat.quat_x = w_quat.x;
    assign o_quat.quat_y = w_quat.y;
    assign o_quat.quat_z = w_quat.z;

    a_ready_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_quat.ready |-> i_angle.ready)
        else $error("request side stalled while the receiver is ready");

    a_range_wx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_quat.valid |-> (o_quat.quat_w <= OneQ14 && o_quat.quat_w >= -OneQ14
                          && o_quat.quat_x <= OneQ14 && o_quat.quat_x >= -OneQ14))
        else $error("w or x component outside plus or minus one");

    a_range_yz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_quat.valid |-> (o_quat.quat_y <= OneQ14 && o_quat.quat_y >= -OneQ14
                          && o_quat.quat_z <= OneQ14 && o_quat.quat_z >= -OneQ14))
        else $error("y or z component outside plus or minus one");

    a_cell_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_angle.valid && i_angle.ready) |=> w_valid[1])
        else $error("accepted request did not enter the first cell");
endmodule
